FILE: rtl/core/esqrt_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the exact integer square root block.
package esqrt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int ROOT_WIDTH  = 16;

endpackage

FILE: rtl/core/esqrt_cell.sv
`timescale 1ns / 1ps
// One restoring square root cell: resolves one root bit and registers the partial result.
module esqrt_cell #(
    parameter int WIDTH = 32,
    parameter int SHIFT = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic             in_neg,
    input  logic [WIDTH-1:0] in_x,
    input  logic [WIDTH-1:0] in_rem,
    input  logic [WIDTH-1:0] in_res,
    output logic             out_valid,
    output logic             out_neg,
    output logic [WIDTH-1:0] out_x,
    output logic [WIDTH-1:0] out_rem,
    output logic [WIDTH-1:0] out_res
);

    localparam logic [WIDTH:0] BIT = (WIDTH + 1)'(1) << SHIFT;

    logic             valid_reg;
    logic             neg_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] res_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] res_next;
    logic [WIDTH:0]   trial;

    always_comb
    begin
        trial = {1'b0, in_res} + BIT;
        if ({1'b0, in_rem} >= trial)
        begin
            rem_next = in_rem - trial[WIDTH-1:0];
            res_next = (in_res >> 1) + BIT[WIDTH-1:0];
        end
        else
        begin
            rem_next = in_rem;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            neg_reg <= in_neg;
            x_reg   <= in_x;
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_x     = x_reg;
    assign out_rem   = rem_reg;
    assign out_res   = res_reg;

endmodule

FILE: rtl/core/esqrt_check.sv
`timescale 1ns / 1ps
// Exactness check: squares the floor root, compares with the operand and holds the result.
module esqrt_check #(
    parameter int DATA_WIDTH = 32,
    parameter int RW         = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic                  in_neg,
    input  logic [DATA_WIDTH-1:0] in_x,
    input  logic [DATA_WIDTH-1:0] in_res,
    output logic                  out_valid,
    output logic [RW-1:0]         out_root,
    output logic                  out_hit
);

    logic            valid_reg;
    logic [RW-1:0]   root_reg;
    logic            hit_reg;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] square;
    logic [2*RW-1:0] x_wide;
    logic            hit_next;
    logic [RW-1:0]   root_next;

    always_comb
    begin
        root_in   = in_res[RW-1:0];
        square    = (2 * RW)'(root_in) * (2 * RW)'(root_in);
        x_wide    = (2 * RW)'(in_x);
        hit_next  = !in_neg && (square == x_wide);
        root_next = hit_next ? root_in : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            root_reg <= root_next;
            hit_reg  <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_root  = root_reg;
    assign out_hit   = hit_reg;

endmodule

FILE: rtl/core/exact_integer_square_root.sv
`timescale 1ns / 1ps
// Exact integer square root: a chain of restoring cells followed by a square-and-compare stage.
// Each cell of the chain resolves one root bit.
// Throughput: one transaction per cycle unless out_stall holds a finished result.
// The whole chain freezes while a finished result waits under out_stall.
// Reset clears the valid bits of every stage; payload registers are not reset.
module exact_integer_square_root #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [esqrt_pkg::VALUE_WIDTH-1:0] value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [esqrt_pkg::ROOT_WIDTH-1:0]     root,
    output logic                                 is_square
);

    localparam int NSTEPS = (DATA_WIDTH + 1) / 2;
    localparam int TOP    = 2 * (NSTEPS - 1);
    localparam int VW     = esqrt_pkg::VALUE_WIDTH;
    localparam int OW     = esqrt_pkg::ROOT_WIDTH;

    logic                  advance;
    logic [DATA_WIDTH+VW-1:0] value_ext;
    logic [DATA_WIDTH-1:0] operand;

    logic                  st_valid [0:NSTEPS];
    logic                  st_neg   [0:NSTEPS];
    logic [DATA_WIDTH-1:0] st_x     [0:NSTEPS];
    logic [DATA_WIDTH-1:0] st_rem   [0:NSTEPS];
    logic [DATA_WIDTH-1:0] st_res   [0:NSTEPS];

    logic [NSTEPS-1:0]     chk_root;
    logic                  chk_hit;
    logic [NSTEPS+OW-1:0]  root_ext;

    // hold the chain while the result is stalled
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    assign value_ext = {DATA_WIDTH'(0), value};
    assign operand   = value_ext[DATA_WIDTH-1:0];

    assign st_valid[0] = in_valid;
    assign st_neg[0]   = operand[DATA_WIDTH-1];
    assign st_x[0]     = operand;
    assign st_rem[0]   = operand;
    assign st_res[0]   = '0;

    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_cell
        esqrt_cell #(
            .WIDTH (DATA_WIDTH),
            .SHIFT (TOP - 2 * i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (st_valid[i]),
            .in_neg    (st_neg[i]),
            .in_x      (st_x[i]),
            .in_rem    (st_rem[i]),
            .in_res    (st_res[i]),
            .out_valid (st_valid[i+1]),
            .out_neg   (st_neg[i+1]),
            .out_x     (st_x[i+1]),
            .out_rem   (st_rem[i+1]),
            .out_res   (st_res[i+1])
        );
    end

    esqrt_check #(
        .DATA_WIDTH (DATA_WIDTH),
        .RW         (NSTEPS)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (st_valid[NSTEPS]),
        .in_neg    (st_neg[NSTEPS]),
        .in_x      (st_x[NSTEPS]),
        .in_res    (st_res[NSTEPS]),
        .out_valid (out_valid),
        .out_root  (chk_root),
        .out_hit   (chk_hit)
    );

    assign root_ext  = {OW'(0), chk_root};
    assign root      = root_ext[OW-1:0];
    assign is_square = chk_hit;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for the exact integer square root block: queued driver, checking monitor.
module tb;

    import esqrt_pkg::*;

    localparam int TOP_PROBE = (VALUE_WIDTH - 1) & ~1;
    localparam int MAX_ROOT  = 46340;

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] operand;
        logic                          wait_for_drain;
    } pending_item_t;

    typedef struct {
        logic [ROOT_WIDTH-1:0] root;
        logic                  is_square;
    } root_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [ROOT_WIDTH-1:0]         root;
    logic                          is_square;

    pending_item_t pending_values[$];
    root_result_t  expected_roots[$];

    int mismatches = 0;
    int send_gap = 0;
    int stall_left = 0;
    int sent_count = 0;
    int recv_count = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    exact_integer_square_root dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root      (root),
        .is_square (is_square)
    );

    function automatic root_result_t exact_root_of(input logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH+1:0] rem;
        logic [VALUE_WIDTH+1:0] acc;
        logic [VALUE_WIDTH+1:0] probe;
        root_result_t           res;
        res.root      = '0;
        res.is_square = 1'b0;
        if (v[VALUE_WIDTH-1])
            return res;
        rem   = {2'b00, v};
        acc   = '0;
        probe = {{(VALUE_WIDTH+1){1'b0}}, 1'b1} << TOP_PROBE;
        while (probe != 0)
        begin
            if (rem >= acc + probe)
            begin
                rem = rem - (acc + probe);
                acc = (acc >> 1) + probe;
            end
            else
            begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        if (acc * acc == {2'b00, v})
        begin
            res.root      = acc[ROOT_WIDTH-1:0];
            res.is_square = 1'b1;
        end
        return res;
    endfunction

    task automatic queue_value(input logic signed [VALUE_WIDTH-1:0] v, input logic drain);
        pending_item_t item;
        item.operand        = v;
        item.wait_for_drain = drain;
        pending_values.push_back(item);
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        pending_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_roots.push_back(exact_root_of(value));
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_values.size() != 0 &&
                     !(pending_values[0].wait_for_drain &&
                       (expected_roots.size() != 0 || in_valid)))
            begin
                item = pending_values.pop_front();
                if (sent_count % 50 == 0)
                    send_steady = ($urandom_range(0, 3) == 0);
                sent_count++;
                in_valid <= 1'b1;
                value    <= item.operand;
                send_gap <= send_steady ? 0 : $urandom_range(0, 10);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        root_result_t want;
        int           next_stall;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            next_stall = stall_left;
            if (out_valid && !out_stall)
            begin
                if (expected_roots.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: root=%0d is_square=%0b",
                                 root, is_square);
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (root !== want.root || is_square !== want.is_square)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %0d/%0b, got %0d/%0b",
                                     recv_count, want.root, want.is_square,
                                     root, is_square);
                    end
                end
                if (recv_count % 50 == 0)
                    recv_steady = ($urandom_range(0, 3) == 0);
                recv_count++;
                next_stall = recv_steady ? 0 : $urandom_range(0, 10);
            end
            else if (stall_left != 0)
            begin
                next_stall = stall_left - 1;
            end
            stall_left <= next_stall;
            out_stall  <= (next_stall != 0);
        end
    end

    initial
    begin
        int kind;
        int r;
        logic signed [VALUE_WIDTH-1:0] v;

        queue_value(32'sd0, 1'b0);
        queue_value(32'sd1, 1'b0);
        queue_value(32'sd2, 1'b0);
        queue_value(32'sd3, 1'b0);
        queue_value(32'sd4, 1'b0);
        queue_value(32'sd15, 1'b0);
        queue_value(32'sd16, 1'b0);
        queue_value(32'sd17, 1'b0);
        queue_value(-32'sd1, 1'b0);
        queue_value(32'sh8000_0000, 1'b0);
        queue_value(32'sh7FFF_FFFF, 1'b0);
        queue_value(MAX_ROOT * MAX_ROOT, 1'b0);
        queue_value(MAX_ROOT * MAX_ROOT - 1, 1'b0);
        queue_value(MAX_ROOT * MAX_ROOT + 1, 1'b0);
        queue_value(32'sh4000_0000, 1'b0);
        queue_value(32'sh0001_0000, 1'b0);
        queue_value(32'sh5555_5555, 1'b0);
        queue_value(32'shAAAA_AAAA, 1'b0);
        queue_value(32'sh3FFF_0001, 1'b0);
        queue_value(32'sd65025, 1'b0);
        queue_value(32'sd1073676289, 1'b0);

        for (int i = 0; i < 1630; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                r = $urandom_range(0, MAX_ROOT);
                v = r * r;
            end
            else if (kind < 55)
            begin
                r = $urandom_range(1, MAX_ROOT);
                v = $urandom_range(0, 1) ? r * r + 1 : r * r - 1;
            end
            else if (kind < 80)
            begin
                v = $urandom;
            end
            else if (kind < 90)
            begin
                v = $urandom_range(0, 1023);
            end
            else
            begin
                v = $urandom | 32'h8000_0000;
            end
            queue_value(v, i == 0 || i == 800 || $urandom_range(0, 199) == 0);
        end

        while (pending_values.size() != 0 || in_valid || expected_roots.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        mismatches += expected_roots.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/esqrt_pkg.sv
rtl/core/esqrt_cell.sv
rtl/core/esqrt_check.sv
rtl/core/exact_integer_square_root.sv
test/tb.sv
